// File: hw/rtl/htbe_pkg.sv
// Package: widths, fixed-point constants, stage payload types and shared helpers.
package htbe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TIME_W    = 32;
    localparam int DIFF_W    = TIME_W + 1;
    localparam int STEP_W    = 31;
    localparam int OUT_W     = 32;
    localparam int CAP_BITS  = 46;
    localparam int COEF_W    = CAP_BITS + 2;

    // front multiply: |t - tj| (32b) times inverse step
    localparam int PROD_W    = TIME_W + STEP_W;
    localparam int M_W       = PROD_W - FRAC_BITS;

    // derivative cells: magnitude split in two halves
    localparam int HALF_W    = COEF_W / 2;
    localparam int PP_W      = HALF_W + STEP_W;
    localparam int FULL_W    = COEF_W + STEP_W;
    localparam int DM_W      = FULL_W - FRAC_BITS;

    // Horner cells: clamped accumulator times z
    localparam int Z_W       = FRAC_BITS + 1;
    localparam int HP_W      = CAP_BITS + Z_W;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [Z_W-1:0]           z_t;
    typedef logic [1:0]               dcnt_t;

    localparam logic [COEF_W-1:0] CAP_MAG = COEF_W'((64'd1 << CAP_BITS) - 64'd1);
    localparam coef_t CAP_Q   = coef_t'(CAP_MAG);
    localparam coef_t Q_ONE   = coef_t'(1 << FRAC_BITS);
    localparam coef_t Q_TWO   = coef_t'(2 << FRAC_BITS);
    localparam coef_t Q_THREE = coef_t'(3 << FRAC_BITS);
    localparam z_t    Z_ONE   = z_t'(1 << FRAC_BITS);
    localparam coef_t OUT_MAX = coef_t'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam coef_t OUT_MIN = -coef_t'(64'sd1 <<< (OUT_W - 1));
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1 << FRAC_BITS);

    typedef enum logic {
        REG_TIME_STEP    = 1'b0,
        REG_INVERSE_STEP = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [STEP_W-1:0] time_step;
        logic [STEP_W-1:0] inverse_step;
    } cfg_t;

    // beat handed from cell to cell
    typedef struct packed {
        coef_t [3:0] c;     // polynomial coefficients, c[0] constant term
        coef_t       acc;   // Horner accumulator
        z_t          z;     // local coordinate within the piece
        dcnt_t       cnt;   // derivatives still to take
    } cell_data_t;

    function automatic coef_t sat_cap(input logic signed [COEF_W:0] x);
        logic signed [COEF_W:0] lim;
        lim = (COEF_W + 1)'(CAP_Q);
        if (x > lim) begin
            return CAP_Q;
        end
        else if (x < -lim) begin
            return -CAP_Q;
        end
        else begin
            return coef_t'(x[COEF_W-1:0]);
        end
    endfunction

endpackage

// File: hw/rtl/htbe_front.sv
// Front end: local coordinate z, range test, piece select and base coefficients.
module htbe_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  htbe_pkg::cfg_t                    cfg,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic signed [htbe_pkg::TIME_W-1:0] sample_time,
    input  logic signed [htbe_pkg::TIME_W-1:0] knot_time,
    input  logic                              element_kind,
    input  logic [2:0]                        deriv_order,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output htbe_pkg::cell_data_t              dn_data
);

    // stage 1: difference
    logic                                    s1_vld_reg;
    logic signed [htbe_pkg::DIFF_W-1:0]      s1_diff_reg;
    logic                                    s1_kind_reg;
    logic [2:0]                              s1_order_reg;
    // stage 2: product
    logic                                    s2_vld_reg;
    logic [htbe_pkg::PROD_W-1:0]             s2_prod_reg;
    logic                                    s2_neg_reg;
    logic                                    s2_kind_reg;
    logic [2:0]                              s2_order_reg;
    // stage 3: coefficients
    logic                                    s3_vld_reg;
    htbe_pkg::cell_data_t                    s3_data_reg;
    htbe_pkg::cell_data_t                    s3_next;

    logic                                    ld1, ld2, ld3;
    logic [htbe_pkg::TIME_W-1:0]             diff_mag;
    logic [htbe_pkg::M_W-1:0]                m;
    logic [htbe_pkg::Z_W-1:0]                mz;
    logic                                    in_range;
    logic                                    right;
    htbe_pkg::coef_t                         h;

    assign ld3      = !s3_vld_reg || dn_ready;
    assign ld2      = !s2_vld_reg || ld3;
    assign ld1      = !s1_vld_reg || ld2;
    assign up_ready = ld1;
    assign dn_valid = s3_vld_reg;
    assign dn_data  = s3_data_reg;

    assign diff_mag = (s1_diff_reg < 0) ? htbe_pkg::TIME_W'(-s1_diff_reg)
                                        : htbe_pkg::TIME_W'(s1_diff_reg);

    always_comb
    begin
        m        = htbe_pkg::M_W'(s2_prod_reg >> htbe_pkg::FRAC_BITS);
        mz       = m[htbe_pkg::Z_W-1:0];
        in_range = (m <= htbe_pkg::M_W'(htbe_pkg::Z_ONE));
        right    = !s2_neg_reg && (m != '0);
        h        = htbe_pkg::coef_t'({{(htbe_pkg::COEF_W - htbe_pkg::STEP_W){1'b0}},
                                      cfg.time_step});

        s3_next     = '0;
        s3_next.cnt = s2_order_reg[1:0];
        s3_next.z   = right ? mz : (htbe_pkg::Z_ONE - mz);
        if (!s2_kind_reg) begin
            if (right) begin
                s3_next.c[0] = htbe_pkg::Q_ONE;
                s3_next.c[2] = -htbe_pkg::Q_THREE;
                s3_next.c[3] = htbe_pkg::Q_TWO;
            end
            else begin
                s3_next.c[2] = htbe_pkg::Q_THREE;
                s3_next.c[3] = -htbe_pkg::Q_TWO;
            end
        end
        else begin
            if (right) begin
                s3_next.c[1] = h;
                s3_next.c[2] = -(h <<< 1);
                s3_next.c[3] = h;
            end
            else begin
                s3_next.c[2] = -h;
                s3_next.c[3] = h;
            end
        end
        // |t - tj| scaled above 1.0 or order above three: all-zero polynomial, z cleared
        if (!in_range || s2_order_reg[2]) begin
            s3_next.c = '0;
            s3_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else begin
            if (ld1) s1_vld_reg <= up_valid;
            if (ld2) s2_vld_reg <= s1_vld_reg;
            if (ld3) s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && up_valid) begin
            s1_diff_reg  <= htbe_pkg::DIFF_W'(sample_time) - htbe_pkg::DIFF_W'(knot_time);
            s1_kind_reg  <= element_kind;
            s1_order_reg <= deriv_order;
        end
        if (ld2 && s1_vld_reg) begin
            s2_prod_reg  <= htbe_pkg::PROD_W'(diff_mag) * htbe_pkg::PROD_W'(cfg.inverse_step);
            s2_neg_reg   <= (s1_diff_reg < 0);
            s2_kind_reg  <= s1_kind_reg;
            s2_order_reg <= s1_order_reg;
        end
        if (ld3 && s2_vld_reg) begin
            s3_data_reg <= s3_next;
        end
    end

endmodule

// File: hw/rtl/htbe_diff_cell.sv
// Derivative cell: one optional time derivative of the cubic, two stages.
module htbe_diff_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [htbe_pkg::STEP_W-1:0]       inverse_step,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  htbe_pkg::cell_data_t              up_data,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output htbe_pkg::cell_data_t              dn_data
);

    logic                                     a_vld_reg;
    htbe_pkg::cell_data_t                     a_data_reg;
    logic [htbe_pkg::PP_W-1:0]                a_lo_reg [3];
    logic [htbe_pkg::PP_W-1:0]                a_hi_reg [3];
    logic [2:0]                               a_neg_reg;
    logic                                     b_vld_reg;
    htbe_pkg::cell_data_t                     b_data_reg;

    logic                                     ld_a, ld_b;
    logic signed [htbe_pkg::COEF_W+1:0]       scaled [3];
    logic [htbe_pkg::COEF_W-1:0]              umag [3];
    logic [2:0]                               neg_in;
    logic [htbe_pkg::PP_W-1:0]                lo_in [3];
    logic [htbe_pkg::PP_W-1:0]                hi_in [3];
    logic [htbe_pkg::FULL_W-1:0]              full [3];
    logic [htbe_pkg::DM_W-1:0]                mq [3];
    htbe_pkg::coef_t                          capped [3];
    htbe_pkg::cell_data_t                     b_next;

    assign ld_b     = !b_vld_reg || dn_ready;
    assign ld_a     = !a_vld_reg || ld_b;
    assign up_ready = ld_a;
    assign dn_valid = b_vld_reg;
    assign dn_data  = b_data_reg;

    // stage A: i*c[i], magnitude, two half-width partial products per lane
    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            scaled[k] = (htbe_pkg::COEF_W + 2)'(htbe_pkg::coef_t'(up_data.c[k+1]))
                      * (htbe_pkg::COEF_W + 2)'(k + 1);
            neg_in[k] = (scaled[k] < 0);
            umag[k]   = neg_in[k] ? htbe_pkg::COEF_W'(-scaled[k])
                                  : htbe_pkg::COEF_W'(scaled[k]);
            lo_in[k]  = htbe_pkg::PP_W'(umag[k][htbe_pkg::HALF_W-1:0])
                      * htbe_pkg::PP_W'(inverse_step);
            hi_in[k]  = htbe_pkg::PP_W'(umag[k][htbe_pkg::COEF_W-1:htbe_pkg::HALF_W])
                      * htbe_pkg::PP_W'(inverse_step);
        end
    end

    // stage B: combine, drop fraction, saturate; while cnt > 0, shift coefficients down
    always_comb
    begin
        b_next = a_data_reg;
        for (int k = 0; k < 3; k++) begin
            full[k]   = (htbe_pkg::FULL_W'(a_hi_reg[k]) << htbe_pkg::HALF_W)
                      + htbe_pkg::FULL_W'(a_lo_reg[k]);
            mq[k]     = htbe_pkg::DM_W'(full[k] >> htbe_pkg::FRAC_BITS);
            capped[k] = (mq[k] > htbe_pkg::DM_W'(htbe_pkg::CAP_MAG))
                      ? htbe_pkg::CAP_Q
                      : htbe_pkg::coef_t'(mq[k][htbe_pkg::COEF_W-1:0]);
        end
        if (a_data_reg.cnt != '0) begin
            for (int k = 0; k < 3; k++) begin
                b_next.c[k] = a_neg_reg[k] ? -capped[k] : capped[k];
            end
            b_next.c[3] = '0;
            b_next.cnt  = a_data_reg.cnt - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else begin
            if (ld_a) a_vld_reg <= up_valid;
            if (ld_b) b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_a && up_valid) begin
            a_data_reg <= up_data;
            a_neg_reg  <= neg_in;
            for (int k = 0; k < 3; k++) begin
                a_lo_reg[k] <= lo_in[k];
                a_hi_reg[k] <= hi_in[k];
            end
        end
        if (ld_b && a_vld_reg) begin
            b_data_reg <= b_next;
        end
    end

endmodule

// File: hw/rtl/htbe_horner_cell.sv
// Horner cell: acc = (acc + top coefficient) * z, two stages.
module htbe_horner_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  htbe_pkg::cell_data_t              up_data,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output htbe_pkg::cell_data_t              dn_data
);

    logic                                     a_vld_reg;
    htbe_pkg::cell_data_t                     a_data_reg;
    htbe_pkg::coef_t                          a_sum_reg;
    logic                                     b_vld_reg;
    htbe_pkg::cell_data_t                     b_data_reg;

    logic                                     ld_a, ld_b;
    logic signed [htbe_pkg::COEF_W:0]         sum_w;
    htbe_pkg::cell_data_t                     a_next;
    logic                                     neg;
    logic [htbe_pkg::CAP_BITS-1:0]            um;
    logic [htbe_pkg::HP_W-1:0]                prod;
    htbe_pkg::coef_t                          mval;
    htbe_pkg::cell_data_t                     b_next;

    assign ld_b     = !b_vld_reg || dn_ready;
    assign ld_a     = !a_vld_reg || ld_b;
    assign up_ready = ld_a;
    assign dn_valid = b_vld_reg;
    assign dn_data  = b_data_reg;

    // stage A: clamped sum, next coefficient moves to the top
    always_comb
    begin
        sum_w = (htbe_pkg::COEF_W + 1)'(htbe_pkg::coef_t'(up_data.acc))
              + (htbe_pkg::COEF_W + 1)'(htbe_pkg::coef_t'(up_data.c[3]));
        a_next      = up_data;
        a_next.c[3] = up_data.c[2];
        a_next.c[2] = up_data.c[1];
        a_next.c[1] = up_data.c[0];
        a_next.c[0] = '0;
    end

    // stage B: z <= 1.0, so the product never exceeds the cap
    always_comb
    begin
        neg  = (a_sum_reg < 0);
        um   = neg ? htbe_pkg::CAP_BITS'(-a_sum_reg) : htbe_pkg::CAP_BITS'(a_sum_reg);
        prod = htbe_pkg::HP_W'(um) * htbe_pkg::HP_W'(a_data_reg.z);
        mval = htbe_pkg::coef_t'(prod >> htbe_pkg::FRAC_BITS);
        b_next     = a_data_reg;
        b_next.acc = neg ? -mval : mval;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else begin
            if (ld_a) a_vld_reg <= up_valid;
            if (ld_b) b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_a && up_valid) begin
            a_data_reg <= a_next;
            a_sum_reg  <= htbe_pkg::sat_cap(sum_w);
        end
        if (ld_b && a_vld_reg) begin
            b_data_reg <= b_next;
        end
    end

endmodule

// File: hw/rtl/hermite_time_basis_eval_top.sv
// Top level: config registers, front end, derivative and Horner cell rows, output stage.
//
// Cubic Hermite time-basis evaluator, signed Q16.16.
// Input channel (in_valid / in_stall): one beat carries sample_time, knot_time,
// element_kind and deriv_order; it is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall): one beat per input beat, basis_value,
// in input order; taken when out_valid is high and out_stall low.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 time step,
// index 1 inverse step, both 31-bit unsigned; cfg_ready is always high. Write only
// while no beat is in flight.
// Pipeline: 3 front stages, 3 derivative cells and 3 Horner cells of 2 stages each,
// 1 output register.
// Throughput: one beat per cycle while out_stall is low, set by the row of cells each
// handing its beat to the next every cycle.
// When the receiver stalls, the output register holds its beat and every stage with
// a free slot downstream keeps filling, so bubbles close up before in_stall rises.
// Reset clears all valid bits and loads both steps with 1.0.
module hermite_time_basis_eval_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [htbe_pkg::TIME_W-1:0] sample_time,
    input  logic signed [htbe_pkg::TIME_W-1:0] knot_time,
    input  logic                               element_kind,
    input  logic [2:0]                         deriv_order,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [htbe_pkg::OUT_W-1:0]  basis_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [htbe_pkg::STEP_W-1:0]        cfg_data
);

    logic [htbe_pkg::STEP_W-1:0]      time_step_reg;
    logic [htbe_pkg::STEP_W-1:0]      inverse_step_reg;
    htbe_pkg::cfg_t                   cfg;

    logic                             front_ready;

    // chain links: d_*[0] front end output, h_*[0] = d_*[3], [3] last cell's output
    logic                             d_valid [4];
    logic                             d_ready [4];
    htbe_pkg::cell_data_t             d_data  [4];
    logic                             h_valid [4];
    logic                             h_ready [4];
    htbe_pkg::cell_data_t             h_data  [4];

    logic                             out_vld_reg;
    logic signed [htbe_pkg::OUT_W-1:0] out_val_reg;
    logic                             ld_out;
    logic signed [htbe_pkg::COEF_W:0] fin_w;
    htbe_pkg::coef_t                  fin;
    logic signed [htbe_pkg::OUT_W-1:0] out_next;

    // ---------------- configuration ----------------
    assign cfg_ready        = 1'b1;
    assign cfg.time_step    = time_step_reg;
    assign cfg.inverse_step = inverse_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            time_step_reg    <= htbe_pkg::STEP_RESET;
            inverse_step_reg <= htbe_pkg::STEP_RESET;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (htbe_pkg::cfg_reg_t'(cfg_index))
                htbe_pkg::REG_TIME_STEP:    time_step_reg    <= cfg_data;
                htbe_pkg::REG_INVERSE_STEP: inverse_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- front end: z and base polynomial ----------------
    assign in_stall = !front_ready;

    htbe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .up_valid     (in_valid),
        .up_ready     (front_ready),
        .sample_time  (sample_time),
        .knot_time    (knot_time),
        .element_kind (element_kind),
        .deriv_order  (deriv_order),
        .dn_valid     (d_valid[0]),
        .dn_ready     (d_ready[0]),
        .dn_data      (d_data[0])
    );

    // ---------------- derivative cells: each takes one derivative while cnt > 0 ----
    for (genvar g = 0; g < 3; g++) begin : g_diff
        htbe_diff_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .inverse_step (inverse_step_reg),
            .up_valid     (d_valid[g]),
            .up_ready     (d_ready[g]),
            .up_data      (d_data[g]),
            .dn_valid     (d_valid[g+1]),
            .dn_ready     (d_ready[g+1]),
            .dn_data      (d_data[g+1])
        );
    end

    assign h_valid[0]  = d_valid[3];
    assign d_ready[3]  = h_ready[0];
    assign h_data[0]   = d_data[3];

    // ---------------- Horner cells: cubic, quadratic, linear terms in turn ----------
    for (genvar g = 0; g < 3; g++) begin : g_horner
        htbe_horner_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (h_valid[g]),
            .up_ready (h_ready[g]),
            .up_data  (h_data[g]),
            .dn_valid (h_valid[g+1]),
            .dn_ready (h_ready[g+1]),
            .dn_data  (h_data[g+1])
        );
    end

    // ---------------- output stage: add constant term, saturate to 32 bits ---------
    // after three shifts the constant term sits at c[3]
    assign ld_out     = !out_vld_reg || !out_stall;
    assign h_ready[3] = ld_out;

    always_comb
    begin
        fin_w = (htbe_pkg::COEF_W + 1)'(htbe_pkg::coef_t'(h_data[3].acc))
              + (htbe_pkg::COEF_W + 1)'(htbe_pkg::coef_t'(h_data[3].c[3]));
        fin   = htbe_pkg::sat_cap(fin_w);
        priority if (fin > htbe_pkg::OUT_MAX) begin
            out_next = htbe_pkg::OUT_MAX[htbe_pkg::OUT_W-1:0];
        end
        else if (fin < htbe_pkg::OUT_MIN) begin
            out_next = htbe_pkg::OUT_MIN[htbe_pkg::OUT_W-1:0];
        end
        else begin
            out_next = fin[htbe_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end
        else if (ld_out) begin
            out_vld_reg <= h_valid[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out && h_valid[3]) begin
            out_val_reg <= out_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign basis_value = out_val_reg;

    // ---------------- assertions ----------------
    // back-pressure only reaches the input when the output beat is held
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held output beat");

    // three derivative cells use up every requested order
    a_order_spent: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid[3] |-> (d_data[3].cnt == '0))
        else $error("derivative count left after last cell");

    // local coordinate stays within one piece
    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid[0] |-> (d_data[0].z <= htbe_pkg::Z_ONE))
        else $error("local coordinate above 1.0");

endmodule
